FILE: sv/mvsf_pkg.sv
// Shared constants and types of the mesh vertex sizing field.
`timescale 1ns / 1ps
package mvsf_pkg;
   localparam int VW = 32;            // value width, unsigned fixed point
   localparam int FB = 16;            // fraction bits
   localparam int NW = VW + 2 * FB;   // curvature dividend width
   localparam int RW = 2 * VW;        // square root radicand width
   localparam int TW = FB + 1;        // blend parameter t, 0..1 inclusive
   localparam int SW = FB + 2;        // smoothstep terms
   localparam int MW = VW + SW - FB;  // scaled blend difference
   localparam int KW = 2;             // surface kind width
   localparam int AW = 5;             // register address width
   localparam int IW = AW - 2;        // register index width

   localparam logic [VW-1:0] VMAX = '1;
   localparam logic [TW-1:0] ONE = TW'(1) << FB;

   localparam logic [KW-1:0] KIND_OTHER = KW'(0);
   localparam logic [KW-1:0] KIND_PLANE = KW'(1);
   localparam logic [KW-1:0] KIND_CYL   = KW'(2);
   localparam logic [KW-1:0] KIND_SPARE = KW'(3);

   localparam logic [IW-1:0] REG_GEOM_TOL = IW'(0);
   localparam logic [IW-1:0] REG_MIN_LEN  = IW'(1);
   localparam logic [IW-1:0] REG_MAX_LEN  = IW'(2);
   localparam logic [IW-1:0] REG_UNI_LEN  = IW'(3);
   localparam logic [IW-1:0] REG_BAND     = IW'(4);
   localparam logic [IW-1:0] REG_EDGE_LEN = IW'(5);
   localparam logic [IW-1:0] REG_ADAPTIVE = IW'(6);

   typedef struct packed {
      logic [VW-1:0] curv;
      logic [VW-1:0] fdist;
      logic          plane;
      logic          cyl;
      logic          kzero;
   } mvsf_item_type;

   typedef struct packed {
      mvsf_item_type item;
      logic [RW-1:0] prad;
   } mvsf_div_side_type;

   typedef struct packed {
      mvsf_item_type item;
      logic          sat_p;
      logic          sat_c;
   } mvsf_root_side_type;

   typedef struct packed {
      logic [VW-1:0] curv;
      logic [VW-1:0] fdist;
      logic [VW-1:0] hpatch;
      logic [VW-1:0] hcurv;
      logic [VW-1:0] hreg;
   } mvsf_size_type;

   typedef struct packed {
      logic [VW-1:0] curv;
      logic [VW-1:0] fdist;
      logic [VW-1:0] hpatch;
      logic [VW-1:0] hcurv;
      logic [VW-1:0] hreg;
      logic [VW-1:0] hedge;
      logic [VW-1:0] band;
      logic          far;
   } mvsf_band_side_type;
endpackage

FILE: sv/mvsf_curv_div.sv
// Pipelined restoring divider for the curvature quotient, one quotient bit per stage.
`timescale 1ns / 1ps
module mvsf_curv_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_vld,
   input  logic [mvsf_pkg::NW-1:0]            in_num,
   input  mvsf_pkg::mvsf_div_side_type        in_side,
   output logic                               out_vld,
   output logic [mvsf_pkg::NW-1:0]            out_quo,
   output mvsf_pkg::mvsf_div_side_type        out_side
);
   logic                        vld_ff  [mvsf_pkg::NW];
   logic [mvsf_pkg::VW-1:0]     rem_ff  [mvsf_pkg::NW];
   logic [mvsf_pkg::NW-1:0]     num_ff  [mvsf_pkg::NW];
   logic [mvsf_pkg::NW-1:0]     quo_ff  [mvsf_pkg::NW];
   mvsf_pkg::mvsf_div_side_type side_ff [mvsf_pkg::NW];

   for (genvar g = 0; g < mvsf_pkg::NW; g++) begin : g_stage
      logic                        vld_p;
      logic [mvsf_pkg::VW-1:0]     rem_p;
      logic [mvsf_pkg::NW-1:0]     num_p;
      logic [mvsf_pkg::NW-1:0]     quo_p;
      mvsf_pkg::mvsf_div_side_type side_p;
      logic [mvsf_pkg::VW:0]       rem_sh;
      logic [mvsf_pkg::VW:0]       diff;
      logic                        ge;
      logic [mvsf_pkg::VW-1:0]     rem_in;

      if (g == 0) begin : g_first
         assign vld_p  = in_vld;
         assign rem_p  = '0;
         assign num_p  = in_num;
         assign quo_p  = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[g-1];
         assign rem_p  = rem_ff[g-1];
         assign num_p  = num_ff[g-1];
         assign quo_p  = quo_ff[g-1];
         assign side_p = side_ff[g-1];
      end

      // bring down the next dividend bit, subtract when it fits
      assign rem_sh = {rem_p, num_p[mvsf_pkg::NW-1]};
      assign diff   = rem_sh - {1'b0, side_p.item.curv};
      assign ge     = rem_sh >= {1'b0, side_p.item.curv};
      assign rem_in = ge ? diff[mvsf_pkg::VW-1:0] : rem_sh[mvsf_pkg::VW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (adv) begin
            vld_ff[g] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g]  <= rem_in;
            num_ff[g]  <= num_p << 1;
            quo_ff[g]  <= {quo_p[mvsf_pkg::NW-2:0], ge};
            side_ff[g] <= side_p;
         end
      end
   end

   assign out_vld  = vld_ff[mvsf_pkg::NW-1];
   assign out_quo  = quo_ff[mvsf_pkg::NW-1];
   assign out_side = side_ff[mvsf_pkg::NW-1];
endmodule

FILE: sv/mvsf_sqrt_pair.sv
// Two-lane pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module mvsf_sqrt_pair (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_vld,
   input  logic [mvsf_pkg::RW-1:0]      x_a,
   input  logic [mvsf_pkg::RW-1:0]      x_b,
   input  mvsf_pkg::mvsf_root_side_type in_side,
   output logic                         out_vld,
   output logic [mvsf_pkg::VW-1:0]      root_a,
   output logic [mvsf_pkg::VW-1:0]      root_b,
   output mvsf_pkg::mvsf_root_side_type out_side
);
   logic                         vld_ff  [mvsf_pkg::VW];
   logic [mvsf_pkg::RW-1:0]      rad_ff  [mvsf_pkg::VW][2];
   logic [mvsf_pkg::RW-1:0]      res_ff  [mvsf_pkg::VW][2];
   mvsf_pkg::mvsf_root_side_type side_ff [mvsf_pkg::VW];
   logic [mvsf_pkg::RW-1:0]      x_arr   [2];

   assign x_arr[0] = x_a;
   assign x_arr[1] = x_b;

   for (genvar g = 0; g < mvsf_pkg::VW; g++) begin : g_stage
      localparam logic [mvsf_pkg::RW-1:0] BIT = mvsf_pkg::RW'(1) << (mvsf_pkg::RW - 2 - 2 * g);

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [mvsf_pkg::RW-1:0] rad_p;
         logic [mvsf_pkg::RW-1:0] res_p;
         logic [mvsf_pkg::RW-1:0] trial;
         logic                    ge;

         if (g == 0) begin : g_first
            assign rad_p = x_arr[l];
            assign res_p = '0;
         end else begin : g_next
            assign rad_p = rad_ff[g-1][l];
            assign res_p = res_ff[g-1][l];
         end

         assign trial = res_p + BIT;
         assign ge    = rad_p >= trial;

         always_ff @(posedge clock) begin
            if (adv) begin
               rad_ff[g][l] <= ge ? rad_p - trial : rad_p;
               res_ff[g][l] <= ge ? (res_p >> 1) + BIT : res_p >> 1;
            end
         end
      end

      if (g == 0) begin : g_ctl_first
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[g] <= 1'b0;
            end else if (adv) begin
               vld_ff[g] <= in_vld;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               side_ff[g] <= in_side;
            end
         end
      end else begin : g_ctl_next
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[g] <= 1'b0;
            end else if (adv) begin
               vld_ff[g] <= vld_ff[g-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               side_ff[g] <= side_ff[g-1];
            end
         end
      end
   end

   assign out_vld  = vld_ff[mvsf_pkg::VW-1];
   assign root_a   = res_ff[mvsf_pkg::VW-1][0][mvsf_pkg::VW-1:0];
   assign root_b   = res_ff[mvsf_pkg::VW-1][1][mvsf_pkg::VW-1:0];
   assign out_side = side_ff[mvsf_pkg::VW-1];
endmodule

FILE: sv/mvsf_band_div.sv
// Pipelined divider for the feature blend parameter distance / band.
`timescale 1ns / 1ps
module mvsf_band_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_vld,
   input  mvsf_pkg::mvsf_band_side_type in_side,
   output logic                         out_vld,
   output logic [mvsf_pkg::TW-1:0]      out_t,
   output mvsf_pkg::mvsf_band_side_type out_side
);
   logic                         vld_ff  [mvsf_pkg::FB];
   logic [mvsf_pkg::VW-1:0]      rem_ff  [mvsf_pkg::FB];
   logic [mvsf_pkg::FB-1:0]      quo_ff  [mvsf_pkg::FB];
   mvsf_pkg::mvsf_band_side_type side_ff [mvsf_pkg::FB];

   for (genvar g = 0; g < mvsf_pkg::FB; g++) begin : g_stage
      logic                         vld_p;
      logic [mvsf_pkg::VW-1:0]      rem_p;
      logic [mvsf_pkg::FB-1:0]      quo_p;
      mvsf_pkg::mvsf_band_side_type side_p;
      logic [mvsf_pkg::VW:0]        rem_sh;
      logic [mvsf_pkg::VW:0]        diff;
      logic                         ge;

      if (g == 0) begin : g_first
         // distance below band: integer quotient bits are all zero
         assign vld_p  = in_vld;
         assign rem_p  = in_side.far ? '0 : in_side.fdist;
         assign quo_p  = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[g-1];
         assign rem_p  = rem_ff[g-1];
         assign quo_p  = quo_ff[g-1];
         assign side_p = side_ff[g-1];
      end

      assign rem_sh = {rem_p, 1'b0};
      assign diff   = rem_sh - {1'b0, side_p.band};
      assign ge     = rem_sh >= {1'b0, side_p.band};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (adv) begin
            vld_ff[g] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g]  <= ge ? diff[mvsf_pkg::VW-1:0] : rem_sh[mvsf_pkg::VW-1:0];
            quo_ff[g]  <= {quo_p[mvsf_pkg::FB-2:0], ge};
            side_ff[g] <= side_p;
         end
      end
   end

   assign out_vld  = vld_ff[mvsf_pkg::FB-1];
   assign out_side = side_ff[mvsf_pkg::FB-1];
   assign out_t    = out_side.far ? mvsf_pkg::ONE : {1'b0, quo_ff[mvsf_pkg::FB-1]};
endmodule

FILE: sv/mvsf_blend.sv
// Smoothstep feature blend, minimum and clamp; last stage is the output register.
`timescale 1ns / 1ps
module mvsf_blend (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_vld,
   input  logic [mvsf_pkg::TW-1:0]      in_t,
   input  mvsf_pkg::mvsf_band_side_type in_side,
   input  logic [mvsf_pkg::VW-1:0]      hmin,
   input  logic [mvsf_pkg::VW-1:0]      hmax,
   input  logic [mvsf_pkg::VW-1:0]      uni_len,
   input  logic                         uni_mode,
   output logic                         out_vld,
   output logic [mvsf_pkg::VW-1:0]      out_target,
   output logic [mvsf_pkg::VW-1:0]      out_curv
);
   logic                         vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   mvsf_pkg::mvsf_band_side_type side1_ff, side2_ff, side3_ff;
   logic [mvsf_pkg::TW-1:0]      u_ff;
   logic [mvsf_pkg::SW-1:0]      w_ff;
   logic [mvsf_pkg::SW-1:0]      s_ff;
   logic [mvsf_pkg::MW-1:0]      mag_ff;
   logic                         up_ff;
   logic [mvsf_pkg::VW-1:0]      target_ff, curv_ff;

   logic [2*mvsf_pkg::TW-1:0]          tt;
   logic [mvsf_pkg::TW-1:0]            u_in;
   logic [mvsf_pkg::SW-1:0]            w_in;
   logic [mvsf_pkg::TW+mvsf_pkg::SW-1:0] uw;
   logic [mvsf_pkg::SW-1:0]            s_in;
   logic                               up_in;
   logic [mvsf_pkg::VW-1:0]            diff;
   logic [mvsf_pkg::VW+mvsf_pkg::SW-1:0] dprod;
   logic [mvsf_pkg::MW-1:0]            mag_in;
   logic [mvsf_pkg::MW-1:0]            sum;
   logic [mvsf_pkg::VW-1:0]            feat;
   logic [mvsf_pkg::VW-1:0]            m_a, m_b, m_all, clamped;
   logic [mvsf_pkg::VW-1:0]            target_in;

   // stage 1: t squared and (3 - 2t)
   always_comb begin
      tt   = {{mvsf_pkg::TW{1'b0}}, in_t} * {{mvsf_pkg::TW{1'b0}}, in_t};
      u_in = tt[mvsf_pkg::FB +: mvsf_pkg::TW];
      w_in = (mvsf_pkg::SW'(3) << mvsf_pkg::FB) - {in_t, 1'b0};
   end

   // stage 2: smoothstep weight
   always_comb begin
      uw   = {{mvsf_pkg::SW{1'b0}}, u_ff} * {{mvsf_pkg::TW{1'b0}}, w_ff};
      s_in = uw[mvsf_pkg::FB +: mvsf_pkg::SW];
   end

   // stage 3: scaled difference between regular and edge length
   always_comb begin
      up_in  = side2_ff.hreg >= side2_ff.hedge;
      diff   = up_in ? side2_ff.hreg - side2_ff.hedge : side2_ff.hedge - side2_ff.hreg;
      dprod  = {{mvsf_pkg::SW{1'b0}}, diff} * {{mvsf_pkg::VW{1'b0}}, s_ff};
      mag_in = dprod[mvsf_pkg::VW+mvsf_pkg::SW-1:mvsf_pkg::FB];
   end

   // stage 4: feature length, minimum, clamp
   always_comb begin
      sum = {{(mvsf_pkg::MW-mvsf_pkg::VW){1'b0}}, side3_ff.hedge} + mag_ff;
      if (up_ff) begin
         feat = (sum[mvsf_pkg::MW-1:mvsf_pkg::VW] != '0) ? mvsf_pkg::VMAX
                                                           : sum[mvsf_pkg::VW-1:0];
      end else if (mag_ff > {{(mvsf_pkg::MW-mvsf_pkg::VW){1'b0}}, side3_ff.hedge}) begin
         feat = mvsf_pkg::VMAX;
      end else begin
         feat = side3_ff.hedge - mag_ff[mvsf_pkg::VW-1:0];
      end
      m_a     = (side3_ff.hcurv < feat) ? side3_ff.hcurv : feat;
      m_b     = (side3_ff.hpatch < hmax) ? side3_ff.hpatch : hmax;
      m_all   = (m_a < m_b) ? m_a : m_b;
      clamped = (m_all < hmin) ? hmin : m_all;
      if (clamped > hmax) begin
         clamped = hmax;
      end
      target_in = uni_mode ? uni_len : clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff      <= u_in;
         w_ff      <= w_in;
         side1_ff  <= in_side;
         s_ff      <= s_in;
         side2_ff  <= side1_ff;
         mag_ff    <= mag_in;
         up_ff     <= up_in;
         side3_ff  <= side2_ff;
         target_ff <= target_in;
         curv_ff   <= side3_ff.curv;
      end
   end

   assign out_vld    = vld4_ff;
   assign out_target = target_ff;
   assign out_curv   = curv_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(out_vld) && $stable(out_target) && $stable(out_curv))
      else $error("output word changed while stalled");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      adv && vld3_ff && !uni_mode && hmin <= hmax |=>
         out_target >= $past(hmin) && out_target <= $past(hmax))
      else $error("target length outside clamp range");

   a_uni: assert property (@(posedge clock) disable iff (reset)
      adv && vld3_ff && uni_mode |=> out_target == $past(uni_len))
      else $error("uniform length not delivered");
endmodule

FILE: sv/mesh_vertex_sizing_field.sv
// Top level of the mesh vertex sizing field: register file and pipeline glue.
// Pipeline from an accepted req word to its rsp word: 64 divider
// stages, 32 square root stages, one sizing stage, 16 band divider stages,
// four blend stages. Throughput: one vertex per cycle; the whole pipeline
// holds while a finished rsp word waits. Reset clears the valid bits and loads
// the register defaults; csr_pready is always high.
`timescale 1ns / 1ps
module mesh_vertex_sizing_field (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // cyl_radius, max_curvature, feature_distance
   input  logic [3*mvsf_pkg::VW-1:0]     req_tdata,
   // surface_kind
   input  logic [mvsf_pkg::KW-1:0]       req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // target_length, curvature_out
   output logic [2*mvsf_pkg::VW-1:0]     rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mvsf_pkg::AW-1:0]       csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   logic [mvsf_pkg::VW-1:0] eps_ff, min_ff, max_ff, uni_ff, band_ff, edge_ff;
   logic                    adapt_ff;
   logic                    wr_en;
   logic [mvsf_pkg::IW-1:0] reg_idx;

   logic [mvsf_pkg::VW-1:0] eps_eff, hmin_eff, hmax_raw, hmax_eff;
   logic                    uni_mode;
   logic                    adv;

   logic [mvsf_pkg::VW-1:0] rad;
   mvsf_pkg::mvsf_div_side_type  div_in, div_side;
   logic [mvsf_pkg::NW-1:0]      div_num, div_quo;
   logic                         div_vld;

   mvsf_pkg::mvsf_root_side_type rt_in, rt_side;
   logic [mvsf_pkg::RW-1:0]      x_a, x_b;
   logic [mvsf_pkg::VW-1:0]      root_a, root_b;
   logic                         rt_vld;

   mvsf_pkg::mvsf_size_type      sz_in, sz_ff;
   logic                         sz_vld_ff;
   logic [mvsf_pkg::VW-1:0]      hmin_pc;

   mvsf_pkg::mvsf_band_side_type bd_in, bd_side;
   logic                         bd_vld;
   logic [mvsf_pkg::TW-1:0]      bd_t;

   logic [mvsf_pkg::VW-1:0]      target, curv;

   // register file
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[mvsf_pkg::AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff   <= mvsf_pkg::VW'(66);
         min_ff   <= mvsf_pkg::VW'(66);
         max_ff   <= mvsf_pkg::VW'(65536);
         uni_ff   <= '0;
         band_ff  <= '0;
         edge_ff  <= '0;
         adapt_ff <= 1'b1;
      end else if (wr_en) begin
         case (reg_idx)
            mvsf_pkg::REG_GEOM_TOL: eps_ff   <= csr_pwdata[mvsf_pkg::VW-1:0];
            mvsf_pkg::REG_MIN_LEN:  min_ff   <= csr_pwdata[mvsf_pkg::VW-1:0];
            mvsf_pkg::REG_MAX_LEN:  max_ff   <= csr_pwdata[mvsf_pkg::VW-1:0];
            mvsf_pkg::REG_UNI_LEN:  uni_ff   <= csr_pwdata[mvsf_pkg::VW-1:0];
            mvsf_pkg::REG_BAND:     band_ff  <= csr_pwdata[mvsf_pkg::VW-1:0];
            mvsf_pkg::REG_EDGE_LEN: edge_ff  <= csr_pwdata[mvsf_pkg::VW-1:0];
            mvsf_pkg::REG_ADAPTIVE: adapt_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mvsf_pkg::REG_GEOM_TOL: csr_prdata = eps_ff;
         mvsf_pkg::REG_MIN_LEN:  csr_prdata = min_ff;
         mvsf_pkg::REG_MAX_LEN:  csr_prdata = max_ff;
         mvsf_pkg::REG_UNI_LEN:  csr_prdata = uni_ff;
         mvsf_pkg::REG_BAND:     csr_prdata = band_ff;
         mvsf_pkg::REG_EDGE_LEN: csr_prdata = edge_ff;
         mvsf_pkg::REG_ADAPTIVE: csr_prdata = {31'b0, adapt_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // effective limits; the user must change registers only while the pipeline is empty, the block does not enforce it
   always_comb begin
      eps_eff  = (eps_ff != '0) ? eps_ff : mvsf_pkg::VW'(1);
      hmin_eff = (min_ff != '0) ? min_ff : eps_eff;
      if (max_ff != '0) begin
         hmax_raw = max_ff;
      end else if (uni_ff != '0) begin
         hmax_raw = uni_ff;
      end else if (hmin_eff > (mvsf_pkg::VMAX >> 3)) begin
         hmax_raw = mvsf_pkg::VMAX;
      end else begin
         hmax_raw = hmin_eff << 3;
      end
      hmax_eff = (hmax_raw < hmin_eff) ? hmin_eff : hmax_raw;
      uni_mode = !adapt_ff && (uni_ff != '0);
   end

   // one global advance: hold everything while the rsp word is stalled
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // intake: cylinder radicand product and curvature dividend
   always_comb begin
      rad              = req_tdata[mvsf_pkg::VW-1:0];
      div_in.item.curv = req_tdata[2*mvsf_pkg::VW-1:mvsf_pkg::VW];
      div_in.item.fdist = req_tdata[3*mvsf_pkg::VW-1:2*mvsf_pkg::VW];
      div_in.item.plane = req_tuser == mvsf_pkg::KIND_PLANE;
      div_in.item.cyl   = (req_tuser == mvsf_pkg::KIND_CYL) && (rad != '0);
      div_in.item.kzero = div_in.item.curv == '0;
      div_in.prad = {{mvsf_pkg::VW{1'b0}}, rad} * {{mvsf_pkg::VW{1'b0}}, eps_eff};
      div_num     = {eps_eff, {(2*mvsf_pkg::FB){1'b0}}};
   end

   mvsf_curv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_tvalid),
      .in_num   (div_num),
      .in_side  (div_in),
      .out_vld  (div_vld),
      .out_quo  (div_quo),
      .out_side (div_side)
   );

   // radicands are 8 times the product or quotient; a root past the value range saturates
   always_comb begin
      rt_in.item  = div_side.item;
      rt_in.sat_p = (div_side.prad >> (mvsf_pkg::RW - 3)) != '0;
      rt_in.sat_c = (div_quo >> (mvsf_pkg::RW - 3)) != '0;
      x_a         = div_side.prad << 3;
      x_b         = mvsf_pkg::RW'(div_quo << 3);
   end

   mvsf_sqrt_pair u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (div_vld),
      .x_a      (x_a),
      .x_b      (x_b),
      .in_side  (rt_in),
      .out_vld  (rt_vld),
      .root_a   (root_a),
      .root_b   (root_b),
      .out_side (rt_side)
   );

   // patch, curvature and regular length
   always_comb begin
      sz_in.curv  = rt_side.item.curv;
      sz_in.fdist = rt_side.item.fdist;
      if (rt_side.item.plane) begin
         sz_in.hpatch = hmax_eff;
      end else if (rt_side.item.cyl) begin
         sz_in.hpatch = rt_side.sat_p ? mvsf_pkg::VMAX : root_a;
      end else begin
         sz_in.hpatch = (uni_ff != '0) ? uni_ff : hmax_eff;
      end
      if (rt_side.item.kzero) begin
         sz_in.hcurv = hmax_eff;
      end else begin
         sz_in.hcurv = rt_side.sat_c ? mvsf_pkg::VMAX : root_b;
      end
      hmin_pc = (sz_in.hpatch < sz_in.hcurv) ? sz_in.hpatch : sz_in.hcurv;
      sz_in.hreg = (hmin_pc < hmin_eff) ? hmin_eff : hmin_pc;
      if (sz_in.hreg > hmax_eff) begin
         sz_in.hreg = hmax_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sz_vld_ff <= 1'b0;
      end else if (adv) begin
         sz_vld_ff <= rt_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sz_ff <= sz_in;
      end
   end

   // band and edge length
   always_comb begin
      bd_in.curv   = sz_ff.curv;
      bd_in.fdist  = sz_ff.fdist;
      bd_in.hpatch = sz_ff.hpatch;
      bd_in.hcurv  = sz_ff.hcurv;
      bd_in.hreg   = sz_ff.hreg;
      bd_in.hedge  = (edge_ff != '0) ? edge_ff : sz_ff.hreg;
      if (band_ff != '0) begin
         bd_in.band = band_ff;
      end else if (sz_ff.hreg > (mvsf_pkg::VMAX >> 2)) begin
         bd_in.band = mvsf_pkg::VMAX;
      end else begin
         bd_in.band = sz_ff.hreg << 2;
      end
      bd_in.far = sz_ff.fdist >= bd_in.band;
   end

   mvsf_band_div u_band (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (sz_vld_ff),
      .in_side  (bd_in),
      .out_vld  (bd_vld),
      .out_t    (bd_t),
      .out_side (bd_side)
   );

   mvsf_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_vld     (bd_vld),
      .in_t       (bd_t),
      .in_side    (bd_side),
      .hmin       (hmin_eff),
      .hmax       (hmax_eff),
      .uni_len    (uni_ff),
      .uni_mode   (uni_mode),
      .out_vld    (rsp_tvalid),
      .out_target (target),
      .out_curv   (curv)
   );

   assign rsp_tdata = {curv, target};
endmodule

FILE: tb/tb_mesh_vertex_sizing_field.sv
// Testbench for the mesh vertex sizing field: directed and random vertices against a predictor.
`timescale 1ns / 1ps

class sizing_scoreboard;
   logic [31:0] r_eps, r_hmin, r_hmax, r_uni, r_band, r_edge;
   logic        r_adapt;
   logic [31:0] len_q[$];
   logic [31:0] curv_q[$];
   int unsigned mismatches;
   int unsigned checked;

   function void reset_regs();
      r_eps = 66; r_hmin = 66; r_hmax = 65536;
      r_uni = 0; r_band = 0; r_edge = 0; r_adapt = 1;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
         mvsf_pkg::REG_GEOM_TOL: r_eps = v;
         mvsf_pkg::REG_MIN_LEN:  r_hmin = v;
         mvsf_pkg::REG_MAX_LEN:  r_hmax = v;
         mvsf_pkg::REG_UNI_LEN:  r_uni = v;
         mvsf_pkg::REG_BAND:     r_band = v;
         mvsf_pkg::REG_EDGE_LEN: r_edge = v;
         mvsf_pkg::REG_ADAPTIVE: r_adapt = v[0];
         default: ;
      endcase
   endfunction

   // floor(sqrt(8*p)), saturated to 32 bits
   function logic [31:0] root8(logic [127:0] p);
      logic [127:0] x;
      logic [63:0] r, c;
      if (p[127:125] != 0) return '1;
      x = p << 3;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   function logic [31:0] clampv(logic [63:0] x, logic [63:0] lo, logic [63:0] hi);
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      return x[31:0];
   endfunction

   function logic [31:0] target_of(logic [1:0] kind, logic [31:0] rad, logic [31:0] k,
                                   logic [31:0] fdist);
      logic [63:0] eps, hmin, hmax, hpatch, hcurv, hreg, band, hedge, t, u, s, hfeat, h;
      logic [127:0] w;
      if (!r_adapt && r_uni != 0) return r_uni;
      eps = (r_eps != 0) ? r_eps : 1;
      hmin = (r_hmin != 0) ? r_hmin : eps;
      if (r_hmax != 0) hmax = r_hmax;
      else if (r_uni != 0) hmax = r_uni;
      else hmax = (hmin > 64'h1FFF_FFFF) ? 64'hFFFF_FFFF : hmin << 3;
      if (hmax < hmin) hmax = hmin;
      if (kind == mvsf_pkg::KIND_PLANE) hpatch = hmax;
      else if (kind == mvsf_pkg::KIND_CYL && rad != 0)
         hpatch = root8({64'd0, 32'd0, rad} * {64'd0, eps});
      else hpatch = (r_uni != 0) ? r_uni : hmax;
      if (k == 0) hcurv = hmax;
      else begin
         w = ({64'd0, eps} << 32) / {96'd0, k};
         hcurv = root8(w);
      end
      hreg = clampv((hpatch < hcurv) ? hpatch : hcurv, hmin, hmax);
      band = (r_band != 0) ? r_band : ((hreg > 64'h3FFF_FFFF) ? 64'hFFFF_FFFF : hreg << 2);
      hedge = (r_edge != 0) ? r_edge : hreg;
      if (fdist >= band) t = 64'h10000;
      else t = ({32'd0, fdist} << 16) / band;
      u = (t * t) >> 16;
      s = (u * (3 * 64'h10000 - 2 * t)) >> 16;
      if (hreg >= hedge) hfeat = hedge + (((hreg - hedge) * s) >> 16);
      else hfeat = hedge - (((hedge - hreg) * s) >> 16);
      if (hfeat > 64'hFFFF_FFFF) hfeat = 64'hFFFF_FFFF;
      h = hcurv;
      if (hfeat < h) h = hfeat;
      if (hpatch < h) h = hpatch;
      if (hmax < h) h = hmax;
      return clampv(h, hmin, hmax);
   endfunction

   function void note_vertex(logic [1:0] kind, logic [31:0] rad, logic [31:0] k,
                             logic [31:0] fdist);
      len_q.push_back(target_of(kind, rad, k, fdist));
      curv_q.push_back(k);
   endfunction

   function void check_result(logic [31:0] len, logic [31:0] curv);
      logic [31:0] el, ec;
      checked++;
      if (len_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected rsp word len=%h curv=%h", len, curv);
         return;
      end
      el = len_q.pop_front();
      ec = curv_q.pop_front();
      if (el !== len || ec !== curv) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch #%0d: len exp %h got %h, curv exp %h got %h",
                     checked, el, len, ec, curv);
      end
   endfunction

   function int pending();
      return len_q.size();
   endfunction
endclass

module tb_mesh_vertex_sizing_field;
   localparam int LIMIT = 400000;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [3*mvsf_pkg::VW-1:0] req_tdata;   // cyl_radius, max_curvature, feature_distance
   logic [mvsf_pkg::KW-1:0] req_tuser;     // surface_kind
   logic [2*mvsf_pkg::VW-1:0] rsp_tdata;   // target_length, curvature_out
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [mvsf_pkg::AW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   sizing_scoreboard sb;
   int unsigned cycles;
   int unsigned vertices;
   bit rsp_idle_off;

   mesh_vertex_sizing_field uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // check rsp words; the block below drives random backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata[31:0], rsp_tdata[63:32]);
      end
   end

   initial begin
      int n;
      rsp_tready <= 1'b1;
      @(posedge clock);
      while (1) begin
         if (!rsp_idle_off && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= mvsf_pkg::AW'({idx, 2'b00}); csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, v);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send_vertex(logic [1:0] kind, logic [31:0] rad, logic [31:0] k,
                              logic [31:0] fdist, bit gaps);
      int n;
      if (gaps && $urandom_range(0, 6) == 0) begin
         n = $urandom_range(1, 14);
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {fdist, k, rad};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_vertex(kind, rad, k, fdist);
      vertices++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 255);
         3: return $urandom_range(1 << 12, 1 << 20);
         4: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_vertices(int count, bit gaps);
      logic [1:0] kind;
      for (int i = 0; i < count; i++) begin
         kind = 2'($urandom_range(0, 3));
         send_vertex(kind, rand_val(), rand_val(), rand_val(), gaps);
      end
   endtask

   task automatic random_regs();
      logic [31:0] lo, hi;
      lo = $urandom_range(1, 1 << 18);
      hi = lo + $urandom_range(0, 1 << 22);
      csr_write(mvsf_pkg::REG_GEOM_TOL,
                ($urandom_range(0, 3) == 0) ? rand_val() : $urandom_range(1, 4000));
      csr_write(mvsf_pkg::REG_MIN_LEN, ($urandom_range(0, 4) == 0) ? rand_val() : lo);
      csr_write(mvsf_pkg::REG_MAX_LEN, ($urandom_range(0, 4) == 0) ? rand_val() : hi);
      csr_write(mvsf_pkg::REG_UNI_LEN, ($urandom_range(0, 1) == 0) ? 32'd0 : rand_val());
      csr_write(mvsf_pkg::REG_BAND, ($urandom_range(0, 1) == 0) ? 32'd0 : rand_val());
      csr_write(mvsf_pkg::REG_EDGE_LEN, ($urandom_range(0, 1) == 0) ? 32'd0 : rand_val());
      csr_write(mvsf_pkg::REG_ADAPTIVE, ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1);
   endtask

   initial begin
      sb = new();
      sb.reset_regs();
      cycles = 0; vertices = 0; rsp_idle_off = 0;
      reset <= 1;
      req_tvalid <= 0; req_tdata <= '0; req_tuser <= '0;
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0; csr_paddr <= '0; csr_pwdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, each kind, field extremes
      send_vertex(mvsf_pkg::KIND_PLANE, 0, 0, 0, 0);
      send_vertex(mvsf_pkg::KIND_CYL, 32'h10000, 32'h10000, 32'h8000, 0);
      send_vertex(mvsf_pkg::KIND_CYL, 0, 32'h100, 32'h100, 0);   // cylinder without radius
      send_vertex(mvsf_pkg::KIND_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_vertex(mvsf_pkg::KIND_SPARE, 32'h1234, 1, 0, 0);      // unused kind code
      send_vertex(mvsf_pkg::KIND_CYL, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
      send_vertex(mvsf_pkg::KIND_PLANE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0);
      drain();
      // zero registers take their substitutes; saturated roots
      csr_write(mvsf_pkg::REG_GEOM_TOL, 0); csr_write(mvsf_pkg::REG_MIN_LEN, 0);
      csr_write(mvsf_pkg::REG_MAX_LEN, 0); csr_write(mvsf_pkg::REG_UNI_LEN, 0);
      csr_write(mvsf_pkg::REG_BAND, 0); csr_write(mvsf_pkg::REG_EDGE_LEN, 0);
      send_vertex(mvsf_pkg::KIND_CYL, 32'h100, 32'h2, 32'h10, 0);
      send_vertex(mvsf_pkg::KIND_OTHER, 0, 32'h1, 32'h0, 0);
      drain();
      csr_write(mvsf_pkg::REG_GEOM_TOL, 32'hFFFF_FFFF); csr_write(mvsf_pkg::REG_MIN_LEN, 1);
      csr_write(mvsf_pkg::REG_MAX_LEN, 32'hFFFF_FFFF);
      csr_write(mvsf_pkg::REG_EDGE_LEN, 32'hFFFF_FFFF);
      csr_write(mvsf_pkg::REG_BAND, 32'hFFFF_FFFF);
      send_vertex(mvsf_pkg::KIND_CYL, 32'hFFFF_FFFF, 1, 32'h8000_0000, 0);
      send_vertex(mvsf_pkg::KIND_OTHER, 0, 1, 32'hFFFF_FFFF, 0);
      send_vertex(mvsf_pkg::KIND_PLANE, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
      drain();
      // uniform mode, curvature still passes through
      csr_write(mvsf_pkg::REG_UNI_LEN, 32'h0003_0000); csr_write(mvsf_pkg::REG_ADAPTIVE, 0);
      send_vertex(mvsf_pkg::KIND_CYL, 32'h10000, 32'hDEAD_BEEF, 32'h10, 0);
      send_vertex(mvsf_pkg::KIND_OTHER, 0, 32'hFFFF_FFFF, 0, 0);
      drain();
      csr_write(mvsf_pkg::REG_ADAPTIVE, 1);
      send_vertex(mvsf_pkg::KIND_OTHER, 32'h10, 32'h10, 32'h10, 0);  // uniform sets patch length
      drain();

      // random phases, with pauses for idle config writes
      for (int ph = 0; ph < 10; ph++) begin
         random_regs();
         random_vertices(120, 1);
         drain();
      end
      sb.reset_regs();
      csr_write(mvsf_pkg::REG_GEOM_TOL, 66); csr_write(mvsf_pkg::REG_MIN_LEN, 66);
      csr_write(mvsf_pkg::REG_MAX_LEN, 65536);
      csr_write(mvsf_pkg::REG_UNI_LEN, 0); csr_write(mvsf_pkg::REG_BAND, 0);
      csr_write(mvsf_pkg::REG_EDGE_LEN, 0);
      csr_write(mvsf_pkg::REG_ADAPTIVE, 1);
      // last stretch at full rate
      rsp_idle_off = 1;
      random_vertices(200, 0);
      drain();

      $display("covered %0d vertices: defaults, zero and extreme registers, uniform mode,",
               vertices);
      $display("random settings, all kinds; %0d rsp words checked, %0d mismatches",
               sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

FILE: filelist.f
sv/mvsf_pkg.sv
sv/mvsf_curv_div.sv
sv/mvsf_sqrt_pair.sv
sv/mvsf_band_div.sv
sv/mvsf_blend.sv
sv/mesh_vertex_sizing_field.sv
tb/tb_mesh_vertex_sizing_field.sv
